// ----- sv/rppa_pkg.sv -----
package rppa_pkg;

  // Input and output beats
  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_AMOUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN   = 2'd2;

  localparam logic [15:0] GAIN_UNITY = 16'd16384;

  typedef enum logic [2:0] {
    MODE_BRIGHT   = 3'd0,
    MODE_CONTRAST = 3'd1,
    MODE_BAL_RED  = 3'd2,
    MODE_BAL_GRN  = 3'd3,
    MODE_BAL_BLU  = 3'd4,
    MODE_GREY     = 3'd5,
    MODE_SEPIA    = 3'd6,
    MODE_INVERT   = 3'd7
  } mode_e;

  // Per-channel output selection
  typedef enum logic [2:0] {
    OP_PASS,
    OP_OFFSET,
    OP_CONTRAST,
    OP_GREY,
    OP_SEPIA,
    OP_INVERT
  } op_e;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  // Load enables of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Sepia rows in Q0.10; element [0] weighs red, [1] green, [2] blue
  typedef logic [2:0][9:0] coef_row_t;

  localparam coef_row_t SEPIA_RED_ROW = '{10'd194, 10'd787, 10'd402};
  localparam coef_row_t SEPIA_GRN_ROW = '{10'd172, 10'd702, 10'd357};
  localparam coef_row_t SEPIA_BLU_ROW = '{10'd134, 10'd547, 10'd279};

  // floor(n / 3) == (n * 683) >> 11 for every n up to 765
  localparam logic [9:0] DIV3_RECIP = 10'd683;

endpackage

// ----- sv/rgb_pixel_point_adjust.sv -----
// An accepted input beat goes through the stage 1, 2 and 3 registers to its output beat.
// Throughput: one pixel per clock; the three-stage pipeline (products, clamp,
// select/output register) takes a new beat every cycle while it can advance.
// Reset: rst_ni clears all stage valid bits and sets mode to brightness,
// adjust amount to 0 and contrast gain to unity (16384).
module rgb_pixel_point_adjust (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [rppa_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rppa_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // pixel in
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rppa_pkg::pix_in_t                   in_data_i,
  // pixel out
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rppa_pkg::pix_out_t                  out_data_o
);

  // Configuration registers. The user must change them only while the pipeline
  // is empty; the block does not enforce it. The stages read them directly.
  rppa_pkg::mode_e    mode_q;
  logic signed [7:0]  amount_q;
  logic [15:0]        gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rppa_pkg::MODE_BRIGHT;
      amount_q <= 8'sd0;
      gain_q   <= rppa_pkg::GAIN_UNITY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rppa_pkg::CFG_MODE:   mode_q   <= rppa_pkg::mode_e'(cfg_wdata_i[2:0]);
        rppa_pkg::CFG_AMOUNT: amount_q <= $signed(cfg_wdata_i[7:0]);
        rppa_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i[15:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Pipeline flow control. A stage loads when the stage before holds a beat
  // and this one is empty or is handing its beat on in the same cycle.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  rppa_pkg::stage_en_t en;

  always_comb begin
    rdy3  = !v3_q || out_ready_i;
    rdy2  = !v2_q || rdy3;
    rdy1  = !v1_q || rdy2;
    en.s1 = in_valid_i && rdy1;
    en.s2 = v1_q && rdy2;
    en.s3 = v2_q && rdy3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign in_ready_o  = rdy1;
  assign out_valid_o = v3_q;

  // Grey level shared by all channels: sum in stage 1, divide by three with
  // a reciprocal multiply in stage 2.
  logic [9:0]  sum_d, sum_q;
  logic [19:0] div3_prod;
  logic [7:0]  grey_q;

  assign sum_d     = 10'(in_data_i.red_in) + 10'(in_data_i.green_in)
                   + 10'(in_data_i.blue_in);
  assign div3_prod = 20'(sum_q) * 20'(rppa_pkg::DIV3_RECIP);

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      sum_q <= sum_d;
    end
    if (en.s2) begin
      grey_q <= div3_prod[18:11];
    end
  end

  // Map the mode onto the operation each channel shows.
  function automatic rppa_pkg::op_e chan_op(rppa_pkg::mode_e m, rppa_pkg::chan_e ch);
    rppa_pkg::op_e op;
    case (m)
      rppa_pkg::MODE_BRIGHT:   op = rppa_pkg::OP_OFFSET;
      rppa_pkg::MODE_CONTRAST: op = rppa_pkg::OP_CONTRAST;
      rppa_pkg::MODE_BAL_RED:
        op = (ch == rppa_pkg::CH_RED)   ? rppa_pkg::OP_OFFSET : rppa_pkg::OP_PASS;
      rppa_pkg::MODE_BAL_GRN:
        op = (ch == rppa_pkg::CH_GREEN) ? rppa_pkg::OP_OFFSET : rppa_pkg::OP_PASS;
      rppa_pkg::MODE_BAL_BLU:
        op = (ch == rppa_pkg::CH_BLUE)  ? rppa_pkg::OP_OFFSET : rppa_pkg::OP_PASS;
      rppa_pkg::MODE_GREY:     op = rppa_pkg::OP_GREY;
      rppa_pkg::MODE_SEPIA:    op = rppa_pkg::OP_SEPIA;
      default:                 op = rppa_pkg::OP_INVERT;
    endcase
    return op;
  endfunction

  rppa_pkg::op_e op_r, op_g, op_b;

  assign op_r = chan_op(mode_q, rppa_pkg::CH_RED);
  assign op_g = chan_op(mode_q, rppa_pkg::CH_GREEN);
  assign op_b = chan_op(mode_q, rppa_pkg::CH_BLUE);

  // One datapath slice per channel
  rppa_chan u_red (
    .clk_i    (clk_i),
    .en_i     (en),
    .chan_i   (in_data_i.red_in),
    .pix_i    (in_data_i),
    .coef_i   (rppa_pkg::SEPIA_RED_ROW),
    .amount_i (amount_q),
    .gain_i   (gain_q),
    .grey_i   (grey_q),
    .op_i     (op_r),
    .res_o    (out_data_o.red_out)
  );

  rppa_chan u_green (
    .clk_i    (clk_i),
    .en_i     (en),
    .chan_i   (in_data_i.green_in),
    .pix_i    (in_data_i),
    .coef_i   (rppa_pkg::SEPIA_GRN_ROW),
    .amount_i (amount_q),
    .gain_i   (gain_q),
    .grey_i   (grey_q),
    .op_i     (op_g),
    .res_o    (out_data_o.green_out)
  );

  rppa_chan u_blue (
    .clk_i    (clk_i),
    .en_i     (en),
    .chan_i   (in_data_i.blue_in),
    .pix_i    (in_data_i),
    .coef_i   (rppa_pkg::SEPIA_BLU_ROW),
    .amount_i (amount_q),
    .gain_i   (gain_q),
    .grey_i   (grey_q),
    .op_i     (op_b),
    .res_o    (out_data_o.blue_out)
  );

endmodule

// ----- sv/rppa_chan.sv -----
module rppa_chan (
  input  logic                 clk_i,
  input  rppa_pkg::stage_en_t  en_i,
  input  logic [7:0]           chan_i,
  input  rppa_pkg::pix_in_t    pix_i,
  input  rppa_pkg::coef_row_t  coef_i,
  input  logic signed [7:0]    amount_i,
  input  logic [15:0]          gain_i,
  input  logic [7:0]           grey_i,
  input  rppa_pkg::op_e        op_i,
  output logic [7:0]           res_o
);

  // Stage 1: products and raw sums
  logic signed [9:0]  off_d, off_q;
  logic signed [25:0] con_d, con_q;
  logic [17:0]        prod_r_d, prod_g_d, prod_b_d;
  logic [17:0]        prod_r_q, prod_g_q, prod_b_q;
  logic [7:0]         c1_q;

  // Stage 2: clamped candidates
  logic signed [25:0] con_bias;
  logic [18:0]        sep_sum;
  logic [7:0]         off8_d, con8_d, sep8_d;
  logic [7:0]         off8_q, con8_q, sep8_q, c2_q;

  // Stage 3: selected result
  logic [7:0]         res_d, res_q;

  always_comb begin
    off_d    = $signed({2'b00, chan_i}) + 10'(amount_i);
    con_d    = 26'($signed({1'b0, gain_i})) * 26'($signed({1'b0, chan_i} - 9'd128));
    prod_r_d = 18'(pix_i.red_in)   * 18'(coef_i[0]);
    prod_g_d = 18'(pix_i.green_in) * 18'(coef_i[1]);
    prod_b_d = 18'(pix_i.blue_in)  * 18'(coef_i[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      off_q    <= off_d;
      con_q    <= con_d;
      prod_r_q <= prod_r_d;
      prod_g_q <= prod_g_d;
      prod_b_q <= prod_b_d;
      c1_q     <= chan_i;
    end
  end

  always_comb begin
    // offset: clamp to 0..255
    if (off_q[9]) begin
      off8_d = 8'd0;
    end else if (off_q[8]) begin
      off8_d = 8'd255;
    end else begin
      off8_d = off_q[7:0];
    end

    // contrast: add the 128 bias in signed Q11.14, drop the fraction, clamp
    con_bias = con_q + 26'sd2097152;
    if (con_bias[25] || (con_bias == 26'sd0)) begin
      con8_d = 8'd0;
    end else if (|con_bias[24:22]) begin
      con8_d = 8'd255;
    end else begin
      con8_d = con_bias[21:14];
    end

    // sepia: drop the Q0.10 fraction, clamp the top
    sep_sum = 19'(prod_r_q) + 19'(prod_g_q) + 19'(prod_b_q);
    if (sep_sum[18]) begin
      sep8_d = 8'd255;
    end else begin
      sep8_d = sep_sum[17:10];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      off8_q <= off8_d;
      con8_q <= con8_d;
      sep8_q <= sep8_d;
      c2_q   <= c1_q;
    end
  end

  always_comb begin
    case (op_i)
      rppa_pkg::OP_OFFSET:   res_d = off8_q;
      rppa_pkg::OP_CONTRAST: res_d = con8_q;
      rppa_pkg::OP_GREY:     res_d = grey_i;
      rppa_pkg::OP_SEPIA:    res_d = sep8_q;
      rppa_pkg::OP_INVERT:   res_d = ~c2_q;
      default:               res_d = c2_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
